// ----- sv/ultrasonic_echo_ranger_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ultrasonic echo ranger
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define UER_ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("uer: implication check failed");

// next-cycle implication
`define UER_ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("uer: next-cycle check failed");

`else

`define UER_ASSERT_IMP(name, clk, rstn, ante, cons)
`define UER_ASSERT_NXT(name, clk, rstn, ante, cons)

`endif

`endif

// ----- sv/uer_pkg.sv -----
// ----------------------------------------------------------------------------
// uer_pkg
// Shared types, constants and helpers of the ultrasonic echo ranger.
// ----------------------------------------------------------------------------
package uer_pkg;

  // counter widths
  localparam int unsigned US_W  = 18;
  localparam int unsigned PRE_W = 8;
  localparam logic [US_W-1:0] US_MAX = '1;

  // configuration port
  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 18;

  // queue between front and back
  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  // distance arithmetic
  localparam int unsigned PROD_W      = 26;  // 16-bit width times 10-bit speed
  localparam int unsigned DIST_W      = 25;  // product halved
  localparam int unsigned X_W         = 19;  // distance divided by 64
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned QM_W        = X_W + RECIP_W;
  localparam int unsigned RECIP_SHIFT = 33;
  localparam int unsigned M_W         = 6;
  localparam int unsigned UM_W        = 20;
  // floor(2^33 / 15625): quotient by 15625 after the shift by 6
  localparam logic [RECIP_W-1:0] RECIP  = 20'd549755;
  localparam logic [PROD_W-1:0]  UM_PER_M = 26'd1000000;

  typedef enum logic [1:0] {
    ST_VALID   = 2'd0,
    ST_WINDOW  = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic [CFG_AW-1:0] {
    REG_CYCLES_PER_US = 3'd0,
    REG_TRIGGER_US    = 3'd1,
    REG_MIN_PULSE_US  = 3'd2,
    REG_MAX_PULSE_US  = 3'd3,
    REG_TIMEOUT_US    = 3'd4,
    REG_HOLDOFF_US    = 3'd5,
    REG_SOUND_SPEED   = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  cycles_per_us;
    logic [7:0]  trigger_us;
    logic [15:0] min_pulse_us;
    logic [15:0] max_pulse_us;
    logic [17:0] timeout_us;
    logic [9:0]  holdoff_us;
    logic [9:0]  sound_speed;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    cycles_per_us: 8'd16,
    trigger_us:    8'd11,
    min_pulse_us:  16'd11,
    max_pulse_us:  16'd25000,
    timeout_us:    18'd130000,
    holdoff_us:    10'd145,
    sound_speed:   10'd340
  };

  // one classified beat from the front
  typedef struct packed {
    logic           trig;
    logic           busy;
    logic           done;
    status_e        status;
    logic [US_W-1:0] pulse_us;
  } res_t;

  // microsecond count plus prescaler remainder
  typedef struct packed {
    logic [US_W-1:0]  us;
    logic [PRE_W-1:0] sub;
  } tick_cnt_t;

  // advance a count by one clock cycle, saturating the microseconds
  function automatic tick_cnt_t advance(tick_cnt_t c, logic [PRE_W-1:0] cpu);
    tick_cnt_t      n;
    logic [PRE_W:0] nxt;
    n   = c;
    nxt = {1'b0, c.sub} + {{PRE_W{1'b0}}, 1'b1};
    if (nxt >= {1'b0, cpu}) begin
      n.sub = '0;
      if (c.us != US_MAX) begin
        n.us = c.us + 1'b1;
      end
    end else begin
      n.sub = nxt[PRE_W-1:0];
    end
    return n;
  endfunction

endpackage

// ----- sv/uer_front.sv -----
// ----------------------------------------------------------------------------
// uer_front
// Measurement sequencer: takes one beat per cycle while the queue has room, tracks the
// echo edges, trigger, timeout and holdoff, and pushes one classified record per beat.
// ----------------------------------------------------------------------------
module uer_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  uer_pkg::cfg_t cfg_i,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          op_i,
  input  logic          echo_i,
  input  logic          full_i,
  output logic          push_o,
  output uer_pkg::res_t push_res_o
);
  import uer_pkg::*;

  localparam logic [2:0] PH_IDLE        = 3'd0;
  localparam logic [2:0] PH_TRIG_FIRST  = 3'd1;
  localparam logic [2:0] PH_TRIG_SECOND = 3'd2;
  localparam logic [2:0] PH_WAIT_FIRST  = 3'd3;
  localparam logic [2:0] PH_WAIT_SECOND = 3'd4;
  localparam logic [2:0] PH_HOLDOFF     = 3'd5;

  logic [2:0]       phase_q, phase_d;
  logic             prev_q, prev_d;
  tick_cnt_t        ph_q, ph_d;
  tick_cnt_t        wd_q, wd_d;
  logic [PRE_W-1:0] cpu;
  logic             echo_chg;
  logic [US_W-1:0]  rnd_us;
  res_t             res;

  assign in_ready_o = ~full_i;
  assign push_o     = in_valid_i & in_ready_o;
  assign push_res_o = res;

  // a zero prescaler counts as one cycle per microsecond
  assign cpu      = (cfg_i.cycles_per_us == '0) ? {{(PRE_W-1){1'b0}}, 1'b1}
                                                : cfg_i.cycles_per_us;
  assign echo_chg = echo_i ^ prev_q;

  // next state and record for the current beat
  always_comb begin
    phase_d = phase_q;
    prev_d  = prev_q;
    ph_d    = ph_q;
    wd_d    = wd_q;
    rnd_us  = '0;
    res     = '0;
    if (push_o) begin
      if (op_i) begin
        // start: only from idle
        if (phase_q == PH_IDLE) begin
          phase_d = PH_TRIG_FIRST;
          ph_d    = '0;
          wd_d    = '0;
        end
      end else begin
        prev_d = echo_i;
        if (phase_q == PH_HOLDOFF) begin
          ph_d = advance(ph_q, cpu);
          if (ph_d.us >= {{(US_W-10){1'b0}}, cfg_i.holdoff_us}) begin
            phase_d = PH_IDLE;
          end
        end else if (phase_q == PH_IDLE || phase_q > PH_WAIT_SECOND) begin
          phase_d = PH_IDLE;
        end else begin
          if (phase_q == PH_TRIG_SECOND || phase_q == PH_WAIT_SECOND) begin
            wd_d = advance(wd_q, cpu);
          end
          if (echo_chg && (phase_q == PH_TRIG_SECOND || phase_q == PH_WAIT_SECOND)) begin
            // second edge: round half up and classify the width
            rnd_us = wd_d.us;
            if ({wd_d.sub, 1'b0} >= {1'b0, cpu} && wd_d.us != US_MAX) begin
              rnd_us = wd_d.us + 1'b1;
            end
            res.done     = 1'b1;
            res.pulse_us = rnd_us;
            if (rnd_us > {{(US_W-16){1'b0}}, cfg_i.min_pulse_us} &&
                rnd_us < {{(US_W-16){1'b0}}, cfg_i.max_pulse_us}) begin
              res.status = ST_VALID;
              phase_d    = PH_IDLE;
            end else begin
              res.status = ST_WINDOW;
              phase_d    = (cfg_i.holdoff_us == '0) ? PH_IDLE : PH_HOLDOFF;
              ph_d       = '0;
            end
          end else begin
            if (echo_chg) begin
              // first edge: start the width count
              phase_d = phase_q + 3'd1;
              wd_d    = '0;
            end
            ph_d = advance(ph_q, cpu);
            if (phase_d == PH_TRIG_FIRST || phase_d == PH_TRIG_SECOND) begin
              if (ph_d.us >= {{(US_W-8){1'b0}}, cfg_i.trigger_us}) begin
                phase_d = phase_d + 3'd2;
                ph_d    = '0;
              end
            end else if (ph_d.us >= cfg_i.timeout_us) begin
              res.done   = 1'b1;
              res.status = ST_TIMEOUT;
              phase_d    = PH_IDLE;
            end
          end
        end
      end
    end
    res.trig = (phase_d == PH_TRIG_FIRST) || (phase_d == PH_TRIG_SECOND);
    res.busy = (phase_d != PH_IDLE);
  end

  // hold sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      prev_q  <= 1'b0;
      ph_q    <= '0;
      wd_q    <= '0;
    end else begin
      phase_q <= phase_d;
      prev_q  <= prev_d;
      ph_q    <= ph_d;
      wd_q    <= wd_d;
    end
  end

endmodule

// ----- sv/uer_fifo.sv -----
// ----------------------------------------------------------------------------
// uer_fifo
// Short show-ahead queue of classified records between front and back.
// ----------------------------------------------------------------------------
module uer_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  uer_pkg::res_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output uer_pkg::res_t rdata_o
);
  import uer_pkg::*;

  res_t          mem_q [Q_DEPTH];
  logic [Q_AW-1:0] wptr_q, rptr_q;
  logic [Q_AW:0]   cnt_q;

  assign full_o  = (cnt_q == Q_AW'(0) + (Q_AW+1)'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rptr_q];

  // store the entry
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- sv/uer_back.sv -----
// ----------------------------------------------------------------------------
// uer_back
// Distance pipeline: width times speed, halved, split into meters and
// micrometers by a reciprocal multiply with one correction step.
// ----------------------------------------------------------------------------
module uer_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [9:0]             sound_speed_i,
  input  logic                   empty_i,
  input  uer_pkg::res_t          rdata_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic                   trig_o,
  output logic                   busy_res_o,
  output logic                   done_res_o,
  output logic [1:0]             status_o,
  output logic [17:0]            pulse_us_o,
  output logic [5:0]             meters_o,
  output logic [19:0]            micrometers_o
);
  import uer_pkg::*;

  logic                adv;
  logic                a_valid_q, b_valid_q, c_valid_q, o_valid_q;
  res_t                a_res_q, b_res_q, c_res_q, o_res_q;
  logic [PROD_W-1:0]   a_prod_q;
  logic [DIST_W-1:0]   a_dist;
  logic [DIST_W-1:0]   b_dist_q, c_dist_q;
  logic [QM_W-1:0]     b_qm_q;
  logic [M_W-1:0]      b_q_est;
  logic [M_W-1:0]      c_q_q;
  logic [PROD_W-1:0]   c_prod_q;
  logic [PROD_W-1:0]   rem, rem_adj;
  logic [M_W-1:0]      o_m_q;
  logic [UM_W-1:0]     o_um_q;
  logic                a_use;

  // the whole pipeline holds while the output beat waits
  assign adv   = ~(o_valid_q & ~out_ready_i);
  assign pop_o = adv & ~empty_i;
  assign a_use = rdata_i.done & (rdata_i.status == ST_VALID);

  assign a_dist  = a_prod_q[PROD_W-1:1];
  assign b_q_est = b_qm_q[QM_W-1:RECIP_SHIFT];
  assign rem     = {1'b0, c_dist_q} - c_prod_q;
  assign rem_adj = rem - UM_PER_M;

  // stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else if (adv) begin
      a_valid_q <= ~empty_i;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      o_valid_q <= c_valid_q;
    end
  end

  // datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      // width times speed, zero for results without a distance
      a_res_q  <= rdata_i;
      a_prod_q <= a_use ? PROD_W'(rdata_i.pulse_us[15:0] * sound_speed_i) : '0;
      // quotient estimate by 1e6
      b_res_q  <= a_res_q;
      b_dist_q <= a_dist;
      b_qm_q   <= QM_W'(a_dist[DIST_W-1:DIST_W-X_W] * RECIP);
      // estimate times 1e6
      c_res_q  <= b_res_q;
      c_dist_q <= b_dist_q;
      c_q_q    <= b_q_est;
      c_prod_q <= PROD_W'(b_q_est * UM_PER_M);
      // correct an estimate that fell one short
      o_res_q  <= c_res_q;
      if (rem >= UM_PER_M) begin
        o_m_q  <= c_q_q + 1'b1;
        o_um_q <= rem_adj[UM_W-1:0];
      end else begin
        o_m_q  <= c_q_q;
        o_um_q <= rem[UM_W-1:0];
      end
    end
  end

  assign out_valid_o   = o_valid_q;
  assign trig_o        = o_res_q.trig;
  assign busy_res_o    = o_res_q.busy;
  assign done_res_o    = o_res_q.done;
  assign status_o      = o_res_q.status;
  assign pulse_us_o    = o_res_q.pulse_us;
  assign meters_o      = o_m_q;
  assign micrometers_o = o_um_q;

endmodule

// ----- sv/ultrasonic_echo_ranger.sv -----
// Path: each input beat passes the record queue, then stage registers a, b, c and o.
// Throughput: one input beat per cycle unless the queue is full, one result beat per
// cycle unless out_ready_i is low; single-cycle sequencer, 4-stage distance pipeline.
// A 4-entry queue absorbs output stalls; input ready drops only when it fills.
// Reset: asynchronous, active low; registers return to defaults, sequencer idle.
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// Echo-pulse ranger top level: configuration registers, sequencer front,
// record queue and distance back end.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_assert.svh"

module ultrasonic_echo_ranger (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [uer_pkg::CFG_AW-1:0] cfg_addr_i,
  input  logic [uer_pkg::CFG_DW-1:0] cfg_wdata_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic                       op_i,
  input  logic                       echo_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       trig_o,
  output logic                       busy_res_o,
  output logic                       done_res_o,
  output logic [1:0]                 status_o,
  output logic [17:0]                pulse_us_o,
  output logic [5:0]                 meters_o,
  output logic [19:0]                micrometers_o
);
  import uer_pkg::*;

  cfg_t cfg_q;
  logic push, full, pop, empty;
  res_t push_res, head_res;

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_CYCLES_PER_US: cfg_q.cycles_per_us <= cfg_wdata_i[7:0];
        REG_TRIGGER_US:    cfg_q.trigger_us    <= cfg_wdata_i[7:0];
        REG_MIN_PULSE_US:  cfg_q.min_pulse_us  <= cfg_wdata_i[15:0];
        REG_MAX_PULSE_US:  cfg_q.max_pulse_us  <= cfg_wdata_i[15:0];
        REG_TIMEOUT_US:    cfg_q.timeout_us    <= cfg_wdata_i[17:0];
        REG_HOLDOFF_US:    cfg_q.holdoff_us    <= cfg_wdata_i[9:0];
        REG_SOUND_SPEED:   cfg_q.sound_speed   <= cfg_wdata_i[9:0];
        default: ;
      endcase
    end
  end

  uer_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .op_i       (op_i),
    .echo_i     (echo_i),
    .full_i     (full),
    .push_o     (push),
    .push_res_o (push_res)
  );

  uer_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_res),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (head_res)
  );

  uer_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sound_speed_i (cfg_q.sound_speed),
    .empty_i       (empty),
    .rdata_i       (head_res),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trig_o        (trig_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o),
    .pulse_us_o    (pulse_us_o),
    .meters_o      (meters_o),
    .micrometers_o (micrometers_o)
  );

  // result fields stay zero on beats that end no measurement
  `UER_ASSERT_IMP(a_idle_fields_zero, clk_i, rst_ni, out_valid_o && !done_res_o, status_o == ST_VALID && pulse_us_o == '0 && meters_o == '0 && micrometers_o == '0)
  // rejected or timed-out measurements carry no distance
  `UER_ASSERT_IMP(a_bad_no_distance, clk_i, rst_ni, out_valid_o && done_res_o && status_o != ST_VALID, meters_o == '0 && micrometers_o == '0)
  // the correction step leaves the remainder below one meter
  `UER_ASSERT_IMP(a_um_in_range, clk_i, rst_ni, out_valid_o, micrometers_o < UM_PER_M[UM_W-1:0])
  // an unstalled output cycle leaves room in the queue
  `UER_ASSERT_NXT(a_queue_room, clk_i, rst_ni, !(out_valid_o && !out_ready_i), in_ready_o)

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the echo ranger. Every accepted input beat yields
// one result beat; a cycle-level predictor built into the bench computes each
// result and the checker compares the outputs field by field in order. Runs
// directed echo shapes, prescaler and window extremes, then random ranging
// with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;
  localparam logic [63:0] MICRONS_PER_METER = 64'd1000000;

  typedef enum logic [2:0] {
    RS_IDLE,
    RS_PING,
    RS_PING_ECHO,
    RS_LISTEN,
    RS_ECHO,
    RS_HOLD
  } ranger_state_e;

  typedef struct packed {
    logic              trig;
    logic              busy;
    logic              done;
    uer_pkg::status_e  status;
    logic [17:0]       pulse_us;
    logic [5:0]        meters;
    logic [19:0]       micrometers;
  } range_reading_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [uer_pkg::CFG_AW-1:0] cfg_addr_i = '0;
  logic [uer_pkg::CFG_DW-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_ready_o;
  logic                       op_i = 1'b0;
  logic                       echo_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b1;
  logic                       trig_o;
  logic                       busy_res_o;
  logic                       done_res_o;
  logic [1:0]                 status_o;
  logic [17:0]                pulse_us_o;
  logic [5:0]                 meters_o;
  logic [19:0]                micrometers_o;

  // bench bookkeeping
  range_reading_t readings_due[$];
  int unsigned    n_bad = 0;
  int unsigned    beats_sent = 0;
  int unsigned    stall_left = 0;
  bit             idle_on = 1'b1;
  logic           line_lvl = 1'b0;

  // predicted ranger state and registers
  uer_pkg::cfg_t  model_cfg = uer_pkg::CFG_RESET;
  ranger_state_e  rs = RS_IDLE;
  logic           prev_lvl = 1'b0;
  logic [17:0]    ph_us = '0;
  logic [7:0]     ph_sub = '0;
  logic [17:0]    w_us = '0;
  logic [7:0]     w_sub = '0;

  ultrasonic_echo_ranger dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .echo_i        (echo_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .trig_o        (trig_o),
    .busy_res_o    (busy_res_o),
    .done_res_o    (done_res_o),
    .status_o      (status_o),
    .pulse_us_o    (pulse_us_o),
    .meters_o      (meters_o),
    .micrometers_o (micrometers_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic coin();
    return $urandom_range(0, 1) == 1;
  endfunction

  // clock cycles per microsecond as the prescaler sees it
  function automatic int unsigned us_ticks();
    return (model_cfg.cycles_per_us == 0) ? 1 : model_cfg.cycles_per_us;
  endfunction

  // advance a microsecond count by one clock cycle, saturating
  function automatic void bump(inout logic [17:0] us, inout logic [7:0] sub);
    if (int'(sub) + 1 >= us_ticks()) begin
      sub = '0;
      if (us != '1) begin
        us = us + 1'b1;
      end
    end else begin
      sub = sub + 1'b1;
    end
  endfunction

  // compute the result beat of one input beat and advance the predicted state
  function automatic range_reading_t predict_reading(input logic op, input logic echo);
    range_reading_t r;
    logic           flip;
    bit             closed;
    int unsigned    width;
    logic [63:0]    dist_um;
    logic [63:0]    whole;
    logic [63:0]    frac;
    r = '0;
    if (op == OP_START) begin
      if (rs == RS_IDLE) begin
        rs     = RS_PING;
        ph_us  = '0;
        ph_sub = '0;
        w_us   = '0;
        w_sub  = '0;
      end
    end else begin
      flip     = (echo != prev_lvl);
      prev_lvl = echo;
      closed   = 1'b0;
      if (rs == RS_HOLD) begin
        bump(ph_us, ph_sub);
        if (ph_us >= model_cfg.holdoff_us) begin
          rs = RS_IDLE;
        end
      end else if (rs != RS_IDLE) begin
        if (rs == RS_PING_ECHO || rs == RS_ECHO) begin
          bump(w_us, w_sub);
        end
        if (flip) begin
          if (rs == RS_PING || rs == RS_LISTEN) begin
            // first echo change starts the width count
            rs    = (rs == RS_PING) ? RS_PING_ECHO : RS_ECHO;
            w_us  = '0;
            w_sub = '0;
          end else begin
            // second echo change: round half up, then check the window
            closed = 1'b1;
            width  = w_us;
            if (2 * w_sub >= us_ticks() && w_us != '1) begin
              width++;
            end
            r.done     = 1'b1;
            r.pulse_us = width[17:0];
            if (width > model_cfg.min_pulse_us && width < model_cfg.max_pulse_us) begin
              dist_um       = (64'(width) * model_cfg.sound_speed) / 2;
              whole         = dist_um / MICRONS_PER_METER;
              frac          = dist_um % MICRONS_PER_METER;
              r.status      = uer_pkg::ST_VALID;
              r.meters      = whole[5:0];
              r.micrometers = frac[19:0];
              rs            = RS_IDLE;
            end else begin
              r.status = uer_pkg::ST_WINDOW;
              rs       = (model_cfg.holdoff_us == 0) ? RS_IDLE : RS_HOLD;
              ph_us    = '0;
              ph_sub   = '0;
            end
          end
        end
        if (!closed) begin
          bump(ph_us, ph_sub);
          if (rs == RS_PING || rs == RS_PING_ECHO) begin
            if (ph_us >= model_cfg.trigger_us) begin
              rs     = (rs == RS_PING) ? RS_LISTEN : RS_ECHO;
              ph_us  = '0;
              ph_sub = '0;
            end
          end else if (ph_us >= model_cfg.timeout_us) begin
            r.done   = 1'b1;
            r.status = uer_pkg::ST_TIMEOUT;
            rs       = RS_IDLE;
          end
        end
      end
    end
    r.trig = (rs == RS_PING || rs == RS_PING_ECHO);
    r.busy = (rs != RS_IDLE);
    return r;
  endfunction

  // send one input beat, with an optional gap before it
  task automatic send_beat(input logic op, input logic echo);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i       <= op;
    echo_i     <= echo;
    do @(posedge clk_i); while (!in_ready_o);
    readings_due.push_back(predict_reading(op, echo));
    beats_sent++;
    if (op == OP_TICK) begin
      line_lvl = echo;
    end
  endtask

  // drop valid and hold until every expected result beat has arrived
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input uer_pkg::reg_idx_e idx, input int unsigned val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val[uer_pkg::CFG_DW-1:0];
    @(posedge clk_i);
    case (idx)
      uer_pkg::REG_CYCLES_PER_US: model_cfg.cycles_per_us = val[7:0];
      uer_pkg::REG_TRIGGER_US:    model_cfg.trigger_us    = val[7:0];
      uer_pkg::REG_MIN_PULSE_US:  model_cfg.min_pulse_us  = val[15:0];
      uer_pkg::REG_MAX_PULSE_US:  model_cfg.max_pulse_us  = val[15:0];
      uer_pkg::REG_TIMEOUT_US:    model_cfg.timeout_us    = val[17:0];
      uer_pkg::REG_HOLDOFF_US:    model_cfg.holdoff_us    = val[9:0];
      uer_pkg::REG_SOUND_SPEED:   model_cfg.sound_speed   = val[9:0];
      default: ;
    endcase
  endtask

  // write the whole register set back to back
  task automatic program_ranger(input int unsigned cpu, trig, pmin, pmax, tmo, hold, speed);
    write_reg(uer_pkg::REG_CYCLES_PER_US, cpu);
    write_reg(uer_pkg::REG_TRIGGER_US, trig);
    write_reg(uer_pkg::REG_MIN_PULSE_US, pmin);
    write_reg(uer_pkg::REG_MAX_PULSE_US, pmax);
    write_reg(uer_pkg::REG_TIMEOUT_US, tmo);
    write_reg(uer_pkg::REG_HOLDOFF_US, hold);
    write_reg(uer_pkg::REG_SOUND_SPEED, speed);
    cfg_we_i <= 1'b0;
  endtask

  // start, then lead beats at rest, span beats of echo and tail + 1 beats at rest
  task automatic range_once(input int unsigned lead, span, tail);
    logic lvl;
    lvl = line_lvl;
    send_beat(OP_START, coin());
    repeat (lead) send_beat(OP_TICK, lvl);
    repeat (span) begin
      if ($urandom_range(0, 15) == 0) begin
        send_beat(OP_START, coin());
      end
      send_beat(OP_TICK, !lvl);
    end
    repeat (tail + 1) send_beat(OP_TICK, lvl);
  endtask

  // tick until the ranger is idle; hurry forces echo edges while listening
  task automatic quiesce(input bit hurry);
    while (rs != RS_IDLE) begin
      if (hurry && (rs == RS_LISTEN || rs == RS_ECHO)) begin
        send_beat(OP_TICK, !line_lvl);
      end else begin
        send_beat(OP_TICK, line_lvl);
      end
    end
  endtask

  task automatic test_reset_defaults();
    range_once(0, 200, 2);
    quiesce(1'b1);
    wait_drained();
  endtask

  task automatic test_window_edges();
    program_ranger(1, 2, 1, 6, 4, 2, 1023);
    // echo changes while idle are only tracked
    send_beat(OP_TICK, !line_lvl);
    send_beat(OP_TICK, !line_lvl);
    // both echo edges inside the trigger; a second start is ignored
    send_beat(OP_START, 1'b1);
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, !line_lvl);
    send_beat(OP_TICK, !line_lvl);
    // a start during holdoff is dropped as well
    send_beat(OP_START, 1'b1);
    quiesce(1'b0);
    // echo inside the window after the trigger, then one too long
    range_once(2, 3, 0);
    quiesce(1'b0);
    range_once(0, 7, 0);
    quiesce(1'b0);
    // no echo at all: hold the sender mid-measurement, then run to timeout
    send_beat(OP_START, 1'b0);
    send_beat(OP_TICK, line_lvl);
    wait_drained();
    quiesce(1'b0);
    wait_drained();
  endtask

  task automatic test_zero_holdoff();
    program_ranger(2, 1, 3, 5, 6, 0, 777);
    // too short, then restart at once since no holdoff follows
    range_once(1, 2, 0);
    range_once(0, 8, 0);
    // half a microsecond rounds up
    range_once(0, 7, 0);
    range_once(0, 12, 0);
    quiesce(1'b0);
    wait_drained();
  endtask

  task automatic test_prescaler_extremes();
    program_ranger(255, 1, 0, 65535, 3, 0, 1);
    // widest prescaler: an echo just over half a microsecond rounds up
    range_once(0, 128, 0);
    quiesce(1'b0);
    // an echo just under half a microsecond rounds to zero, which is not above a zero minimum
    range_once(0, 127, 0);
    quiesce(1'b0);
    wait_drained();
    // zero prescaler acts as one; empty window and a short holdoff
    program_ranger(0, 255, 65535, 1, 262143, 20, 1023);
    range_once(3, 5, 0);
    quiesce(1'b1);
    wait_drained();
  endtask

  task automatic test_long_echo();
    program_ranger(1, 1, 0, 65535, 262143, 0, 1023);
    range_once(0, 30, 3);
    quiesce(1'b1);
    wait_drained();
  endtask

  task automatic test_random_ranging();
    int unsigned goal;
    int unsigned pick;
    int unsigned pmax;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 3) begin
        idle_on <= 1'b0;
      end
      pmax = $urandom_range(1, 16);
      program_ranger($urandom_range(0, 3), $urandom_range(1, 4), $urandom_range(0, 6), pmax,
                     $urandom_range(1, 10), $urandom_range(0, 5), $urandom_range(1, 1023));
      goal = beats_sent + 30;
      while (beats_sent < goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
          // well-formed measurement with random timing
          quiesce(1'b0);
          range_once($urandom_range(0, us_ticks() * (model_cfg.trigger_us + 1)),
                     $urandom_range(0, us_ticks() * (pmax + 2)), $urandom_range(0, 3));
        end else if (pick < 9) begin
          // noise
          repeat ($urandom_range(1, 8)) begin
            send_beat(($urandom_range(0, 3) == 0) ? OP_START : OP_TICK, coin());
          end
        end else begin
          // broken: one echo edge and nothing after it
          send_beat(OP_START, coin());
          repeat ($urandom_range(0, 4)) send_beat(OP_TICK, line_lvl);
          send_beat(OP_TICK, !line_lvl);
        end
      end
      quiesce(1'b0);
      wait_drained();
    end
  endtask

  // random output stalls in bursts
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      if (stall_left == 0) begin
        out_ready_i <= 1'b1;
      end
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(1, 15);
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      n_bad++;
    end
  endtask

  // compare each result beat with the oldest prediction
  always @(posedge clk_i) begin
    range_reading_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (readings_due.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        n_bad++;
      end else begin
        want = readings_due.pop_front();
        check_field("trig", want.trig, trig_o);
        check_field("busy_res", want.busy, busy_res_o);
        check_field("done_res", want.done, done_res_o);
        check_field("status", want.status, status_o);
        check_field("pulse_us", want.pulse_us, pulse_us_o);
        check_field("meters", want.meters, meters_o);
        check_field("micrometers", want.micrometers, micrometers_o);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_window_edges();
    test_zero_holdoff();
    test_prescaler_extremes();
    test_long_echo();
    test_random_ranging();
    // let any stray beat show up before the verdict
    repeat (20) @(posedge clk_i);
    if (n_bad == 0 && readings_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop
  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

endmodule
